>>> hw/rtl/upd_pkg.sv
// shared types, character constants and hex digit helper for the url percent decoder
package upd_pkg;

   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   // marks a byte that is not a hex digit
   localparam logic [4:0] HEX_NONE = 5'd16;

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int MAX_RESULTS     = 3;

   // escape progress, one-hot
   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_PCT   = 3'b010,
      PH_DIGIT = 3'b100
   } upd_phase_type;

   // results caused by one item
   typedef struct packed {
      logic [1:0]                        count;
      logic                              last;
      logic [MAX_RESULTS-1:0][7:0]       bytes;
   } upd_bundle_type;

   typedef struct packed {
      logic           push;
      upd_bundle_type bundle;
   } upd_push_type;

   function automatic logic [4:0] upd_hex_value(input logic [7:0] b);
      logic [7:0] d;
      d = 8'd0;
      if (b inside {[8'h30:8'h39]}) begin
         d = b - 8'h30;
         return d[4:0];
      end else if (b inside {[8'h61:8'h66]}) begin
         d = b - 8'h61 + 8'd10;
         return d[4:0];
      end else if (b inside {[8'h41:8'h46]}) begin
         d = b - 8'h41 + 8'd10;
         return d[4:0];
      end
      return HEX_NONE;
   endfunction

endpackage

>>> hw/rtl/upd_if.sv
// request and response channel interfaces of the url percent decoder
interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

>>> hw/rtl/upd_front.sv
// front end: accepts items, tracks the escape and builds the result bundle
module upd_front
   import upd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   upd_req_if.sink      req_chan,
   input  logic         q_full,
   output upd_push_type push_out
);

   upd_phase_type phase_ff, phase_in;
   logic [7:0]    held_ff, held_in;
   logic [4:0]    hv, held_hv;
   logic          is_hex, fire;
   logic          fr_emit, fr_to_pct, use_fresh;
   logic [7:0]    fr_byte, pre0, pre1;
   logic [1:0]    pre_cnt, total;

   assign req_chan.ready = !q_full;
   assign fire           = req_chan.valid && req_chan.ready;
   assign hv             = upd_hex_value(req_chan.in_byte);
   assign held_hv        = upd_hex_value(held_ff);
   assign is_hex         = !hv[4];

   always_comb begin
      // byte handled with no escape pending
      fr_emit   = 1'b1;
      fr_to_pct = 1'b0;
      fr_byte   = req_chan.in_byte;
      if (req_chan.in_byte == CH_PLUS) begin
         fr_byte = CH_SPACE;
      end else if (req_chan.in_byte == CH_PERCENT) begin
         fr_emit   = req_chan.in_last;
         fr_to_pct = !req_chan.in_last;
      end

      pre_cnt   = 2'd0;
      pre0      = CH_PERCENT;
      pre1      = held_ff;
      use_fresh = 1'b1;
      phase_in  = fr_to_pct ? PH_PCT : PH_IDLE;
      held_in   = held_ff;

      case (phase_ff)
         PH_PCT: begin
            if (is_hex) begin
               use_fresh = 1'b0;
               if (req_chan.in_last) begin
                  pre_cnt  = 2'd2;
                  pre1     = req_chan.in_byte;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_DIGIT;
                  held_in  = req_chan.in_byte;
               end
            end else begin
               pre_cnt = 2'd1;
            end
         end
         PH_DIGIT: begin
            if (is_hex) begin
               use_fresh = 1'b0;
               pre_cnt   = 2'd1;
               pre0      = {held_hv[3:0], hv[3:0]};
               phase_in  = PH_IDLE;
            end else begin
               pre_cnt = 2'd2;
            end
         end
         default: begin
         end
      endcase

      total = pre_cnt + {1'b0, (use_fresh && fr_emit)};

      push_out.push                = fire && (total != 2'd0);
      push_out.bundle.count        = total;
      push_out.bundle.last         = req_chan.in_last;
      push_out.bundle.bytes[0]     = (pre_cnt != 2'd0) ? pre0 : fr_byte;
      push_out.bundle.bytes[1]     = (pre_cnt == 2'd2) ? pre1 : fr_byte;
      push_out.bundle.bytes[2]     = fr_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (fire) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 8'h00;
      end else if (fire) begin
         held_ff <= held_in;
      end
   end

   // end of string always leaves no escape pending
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      fire && req_chan.in_last |=> phase_ff == PH_IDLE)
      else $error("escape pending after end of string");

   // an item ending the string always produces a result
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      fire && req_chan.in_last |-> push_out.push)
      else $error("end of string produced no result");

endmodule

>>> hw/rtl/upd_queue.sv
// small fifo of result bundles between front and back
module upd_queue
   import upd_pkg::*;
#(
   parameter int WIDTH = $bits(upd_bundle_type),
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == DEPTH_C);
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_C)
      else $error("queue count out of range");

endmodule

>>> hw/rtl/upd_back.sv
// back end: unpacks bundles into single result items on the response channel
module upd_back
   import upd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  upd_bundle_type q_data,
   input  logic           q_empty,
   output logic           q_pop,
   upd_rsp_if.source      rsp_chan
);

   upd_bundle_type hold_ff;
   logic [1:0]     idx_ff, idx_in;
   logic           busy, fire, done, load;

   assign busy  = (hold_ff.count != 2'd0);
   assign fire  = rsp_chan.valid && rsp_chan.ready;
   assign done  = (idx_ff == hold_ff.count - 2'd1);
   assign load  = (!busy || (fire && done)) && !q_empty;
   assign q_pop = load;

   assign rsp_chan.valid    = busy;
   assign rsp_chan.out_byte = hold_ff.bytes[idx_ff];
   assign rsp_chan.out_last = hold_ff.last && done;

   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = 2'd0;
      end else if (fire && !done) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff.count <= 2'd0;
         idx_ff        <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         if (load) begin
            hold_ff <= q_data;
         end else if (fire && done) begin
            hold_ff.count <= 2'd0;
         end
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> idx_ff < hold_ff.count)
      else $error("result index beyond bundle");

endmodule

>>> hw/rtl/url_percent_decoder.sv
// top level of the url percent decoder
//
// req_chan carries the encoded string, one character per item, with in_last
// on its final character. rsp_chan gives the decoded bytes, with out_last on
// the final decoded byte of each string. '+' turns into a space, '%' plus
// two hex digits turns into one byte, a broken or unfinished escape comes
// out literally.
// an item is taken every cycle while the bundle queue has room; each item
// leaves 0 to 3 results, which the back end sends one per cycle while
// rsp_chan is ready, so the sustained rate is one item per cycle as long as
// items give at most one result each. a broken escape gives extra results.
// the first result of an item is written into the queue when the item is
// accepted, then loaded into the output register, where it is valid.
// when rsp_chan stalls, results wait in the output register and up to
// QUEUE_DEPTH bundles pile up in the queue; req_chan.ready drops only once
// the queue is full.
// reset (synchronous, active high) empties the queue, drops the output
// register and clears any pending escape.
module url_percent_decoder
   import upd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   upd_req_if.sink   req_chan,
   upd_rsp_if.source rsp_chan
);

   upd_push_type   front_push;
   upd_bundle_type q_out;
   logic           q_full, q_empty, q_pop;

   // front: escape tracking and bundle build
   upd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push_out (front_push)
   );

   // decoupling queue between front and back
   upd_queue #(
      .WIDTH ($bits(upd_bundle_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push.push),
      .push_data (front_push.bundle),
      .pop       (q_pop),
      .pop_data  (q_out),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: one result item per cycle from the output register while rsp_chan is ready
   upd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_out),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
